// ===== rtl/purf_pkg.sv =====
// ----------------------------------------------------------------------------
// purf_pkg
// Shared types and constants for the polled uart receive fifo core.
// ----------------------------------------------------------------------------
package purf_pkg;

  // default receive ring depth (one slot always stays empty)
  localparam int FIFO_DEPTH_DEF = 16;

  // item kinds
  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_SERIAL = 2'd2;

  // register byte offsets
  localparam logic [2:0] OFS_DATA   = 3'd3;
  localparam logic [2:0] OFS_STATUS = 3'd6;
  localparam logic [2:0] OFS_INJECT = 3'd7;

  // line status bits
  localparam logic [7:0] STATUS_TX_EMPTY   = 8'h20;
  localparam logic [7:0] STATUS_DATA_READY = 8'h01;

  // input word
  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] address;
    logic [7:0] data_byte;
  } in_item_t;

  // result word
  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_dropped;
    logic       rx_popped;
    logic       rx_space;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic commit;
  } purf_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_busy;
  } purf_sts_t;

endpackage

// ===== rtl/purf_ram.sv =====
// ----------------------------------------------------------------------------
// purf_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module purf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/purf_ctrl.sv =====
// ----------------------------------------------------------------------------
// purf_ctrl
// Sequencer: takes one word, waits for the ram read, then commits the result
// into the output register once that register is free.
// ----------------------------------------------------------------------------
module purf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  purf_pkg::purf_sts_t sts,
  output purf_pkg::purf_cmd_t cmd
);
  import purf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // commands
  assign in_stall    = (state_r != ST_IDLE);
  assign cmd.capture = (state_r == ST_IDLE) && in_valid;
  assign cmd.commit  = (state_r == ST_EXEC) && !sts.out_busy;

  // checks
  a_capture_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> (state_r == ST_EXEC))
    else $error("captured word did not move to execute");

  a_commit_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !in_stall)
    else $error("input still stalled after commit");

endmodule

// ===== rtl/purf_dp.sv =====
// ----------------------------------------------------------------------------
// purf_dp
// Datapath: captured word, ring pointers, receive store, decode and the
// output register.
// ----------------------------------------------------------------------------
module purf_dp #(
  parameter int FIFO_DEPTH = purf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  purf_pkg::in_item_t   in_item,
  input  purf_pkg::purf_cmd_t  cmd,
  output purf_pkg::purf_sts_t  sts,
  output logic                 out_valid,
  input  logic                 out_stall,
  output purf_pkg::out_item_t  out_item
);
  import purf_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  in_item_t   item_r;
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  out_item_t  out_item_r, res;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] ram_rdata;
  logic       empty, full, is_push, is_pop, push_ok, ram_we;

  // capture the accepted word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
  end

  // decode
  assign empty   = (wr_ptr_r == rd_ptr_r);
  assign full    = (ring_next(wr_ptr_r) == rd_ptr_r);
  assign is_push = (item_r.kind == KIND_SERIAL) ||
                   ((item_r.kind == KIND_WRITE) && (item_r.address == OFS_INJECT));
  assign is_pop  = (item_r.kind == KIND_READ) && (item_r.address == OFS_DATA) && !empty;
  assign push_ok = is_push && !full;
  assign ram_we  = cmd.commit && push_ok;

  // pointer update
  assign wr_ptr_nxt = push_ok ? ring_next(wr_ptr_r) : wr_ptr_r;
  assign rd_ptr_nxt = is_pop ? ring_next(rd_ptr_r) : rd_ptr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else if (cmd.commit) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  // receive store, always reading the head slot
  purf_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr_r),
    .wdata (item_r.data_byte),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // result word
  always_comb begin
    res = '0;
    if (is_pop) begin
      res.read_data = ram_rdata;
      res.rx_popped = 1'b1;
    end else if ((item_r.kind == KIND_READ) && (item_r.address == OFS_STATUS)) begin
      res.read_data = STATUS_TX_EMPTY | (empty ? 8'h00 : STATUS_DATA_READY);
    end
    if ((item_r.kind == KIND_WRITE) && (item_r.address == OFS_DATA)) begin
      res.tx_valid = 1'b1;
      res.tx_byte  = item_r.data_byte;
    end
    res.rx_dropped = is_push && full;
    res.rx_space   = (ring_next(wr_ptr_nxt) != rd_ptr_nxt);
  end

  // output register
  assign out_valid_nxt = cmd.commit | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_item_r <= res;
    end
  end

  assign sts.out_busy = out_valid_r & out_stall;
  assign out_valid    = out_valid_r;
  assign out_item     = out_item_r;

  // checks
  a_no_write_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !full)
    else $error("store written while ring full");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_ptr_r <= PTR_LAST) && (rd_ptr_r <= PTR_LAST))
    else $error("ring pointer out of range");

endmodule

// ===== rtl/polled_uart_rx_fifo_core.sv =====
// ----------------------------------------------------------------------------
// polled_uart_rx_fifo_core
// Polled uart register model with a receive ring fifo.
// ----------------------------------------------------------------------------
// One input word is a bus read, a bus write or a byte arriving from the
// serial line; each word gives exactly one result word (read data, transmit
// byte, drop / pop flags and fifo space).
// Both channels use valid/stall: a word moves at a clock edge with valid high
// and stall low. The block takes one word at a time: in_stall rises the cycle
// after acceptance and falls once the result is loaded into the output
// register; each word passes an execute step, set by the registered read of the
// receive store. The next word is accepted while a result still waits.
// If out_stall holds the output register full, the finished word waits in
// the execute step and input stays stalled until the register frees.
// The ring holds at most FIFO_DEPTH - 1 bytes.
// Reset (rst_n low, synchronous) empties the ring and clears out_valid; the
// store contents are not cleared, as only written slots are ever read.
// ----------------------------------------------------------------------------
module polled_uart_rx_fifo_core #(
  parameter int FIFO_DEPTH = purf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  purf_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output purf_pkg::out_item_t out_item
);
  import purf_pkg::*;

  purf_cmd_t cmd;
  purf_sts_t sts;

  // sequencer
  purf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath
  purf_dp #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== test/uart_fifo_check.sv =====
// ----------------------------------------------------------------------------
// uart_fifo_check
// Watches both channels of the uart receive fifo core, computes the result
// of every accepted input word from its own copy of the ring and compares
// each accepted result word, field by field, with the oldest one pending.
// ----------------------------------------------------------------------------
module uart_fifo_check #(
  parameter int FIFO_DEPTH = purf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  purf_pkg::in_item_t  in_item,
  input  logic                out_valid,
  input  logic                out_stall,
  input  purf_pkg::out_item_t out_item,
  output int                  fail_count,
  output int                  pending_count
);
  import purf_pkg::*;

  // shadow copy of the receive ring
  logic [7:0]  ring [FIFO_DEPTH];
  int unsigned wr_ptr;
  int unsigned rd_ptr;

  out_item_t   pending_results [$];
  int          errors;

  assign fail_count    = errors;
  assign pending_count = pending_results.size();

  function automatic int unsigned ring_next(input int unsigned p);
    return (p + 1 >= FIFO_DEPTH) ? 0 : p + 1;
  endfunction

  // returns 1 when the byte is lost on a full ring
  function logic ring_push(input logic [7:0] b);
    if (ring_next(wr_ptr) == rd_ptr) return 1'b1;
    ring[wr_ptr] = b;
    wr_ptr = ring_next(wr_ptr);
    return 1'b0;
  endfunction

  // result word for one input word, advancing the shadow ring
  task automatic uart_result(input in_item_t w, output out_item_t r);
    r = '0;
    case (w.kind)
      KIND_READ: begin
        if (w.address == OFS_DATA) begin
          if (wr_ptr != rd_ptr) begin
            r.read_data = ring[rd_ptr];
            r.rx_popped = 1'b1;
            rd_ptr = ring_next(rd_ptr);
          end
        end else if (w.address == OFS_STATUS) begin
          r.read_data = STATUS_TX_EMPTY | ((wr_ptr != rd_ptr) ? STATUS_DATA_READY : 8'h00);
        end
      end
      KIND_WRITE: begin
        if (w.address == OFS_DATA) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = w.data_byte;
        end else if (w.address == OFS_INJECT) begin
          r.rx_dropped = ring_push(w.data_byte);
        end
      end
      KIND_SERIAL: r.rx_dropped = ring_push(w.data_byte);
      default: ;
    endcase
    r.rx_space = (ring_next(wr_ptr) != rd_ptr);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      errors++;
    end
  endtask

  // predict on input words, compare on result words
  always @(posedge clk) begin
    out_item_t r;
    out_item_t w;
    if (!rst_n) begin
      wr_ptr = 0;
      rd_ptr = 0;
      pending_results.delete();
      errors = 0;
    end else begin
      if (in_valid && !in_stall) begin
        uart_result(in_item, r);
        pending_results.push_back(r);
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result word with none pending: %0h", out_item);
          errors++;
        end else begin
          w = pending_results.pop_front();
          check_field("read_data", 32'(w.read_data), 32'(out_item.read_data));
          check_field("tx_valid", 32'(w.tx_valid), 32'(out_item.tx_valid));
          check_field("tx_byte", 32'(w.tx_byte), 32'(out_item.tx_byte));
          check_field("rx_dropped", 32'(w.rx_dropped), 32'(out_item.rx_dropped));
          check_field("rx_popped", 32'(w.rx_popped), 32'(out_item.rx_popped));
          check_field("rx_space", 32'(w.rx_space), 32'(out_item.rx_space));
        end
      end
    end
  end

endmodule

// ===== test/polled_uart_rx_fifo_core_test.sv =====
// ----------------------------------------------------------------------------
// polled_uart_rx_fifo_core_test
// Drives bus reads, bus writes and serial bytes into the uart fifo core with
// random gaps and output stalls, including one long output hold that backs
// the block up; the checker instance predicts and compares every result.
// ----------------------------------------------------------------------------
module polled_uart_rx_fifo_core_test;
  import purf_pkg::*;

  localparam int         DEPTH      = FIFO_DEPTH_DEF;
  localparam int         IDLE_LIMIT = 5000;
  localparam int         SEGMENTS   = 35;
  localparam int         SEG_WORDS  = 50;
  localparam int         LONG_HOLD  = 300;
  localparam int         HOLD_AT    = 300;
  localparam logic [1:0] KIND_NONE  = 2'd3;
  localparam logic [2:0] OFS_BASE   = 3'd0;
  localparam logic [2:0] OFS_SPARE  = 3'd5;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} mix_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  int        fail_count;
  int        pending_count;
  int        idle_cycles;
  bit        sender_calm;

  polled_uart_rx_fifo_core #(.FIFO_DEPTH(DEPTH)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  uart_fifo_check #(.FIFO_DEPTH(DEPTH)) u_check (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_item_t make_word(input logic [1:0] k, input logic [2:0] a,
                                         input logic [7:0] d);
    in_item_t w;
    w.kind      = k;
    w.address   = a;
    w.data_byte = d;
    return w;
  endfunction

  // random word shaped by the current mix
  function automatic in_item_t rand_word(input mix_t mix);
    int unsigned pick;
    logic [7:0]  d;
    pick = $urandom_range(0, 9);
    d    = 8'($urandom_range(0, 255));
    case (mix)
      MIX_FILL: begin
        if (pick < 5) return make_word(KIND_SERIAL, 3'($urandom_range(0, 7)), d);
        if (pick < 8) return make_word(KIND_WRITE, OFS_INJECT, d);
      end
      MIX_DRAIN: begin
        if (pick < 6) return make_word(KIND_READ, OFS_DATA, d);
        if (pick < 8) return make_word(KIND_READ, OFS_STATUS, d);
      end
      default: begin
        case (pick)
          3: return make_word(KIND_READ, OFS_DATA, d);
          4: return make_word(KIND_READ, OFS_STATUS, d);
          5: return make_word(KIND_WRITE, OFS_DATA, d);
          6: return make_word(KIND_WRITE, OFS_INJECT, d);
          7, 8, 9: return make_word(KIND_SERIAL, 3'($urandom_range(0, 7)), d);
          default: ;
        endcase
      end
    endcase
    return make_word(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), d);
  endfunction

  // offer one word after a random gap and wait until it is taken
  task automatic send_word(input in_item_t w);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // receiver: random hold per word, calm stretches, one long hold
  initial begin
    int hold;
    int taken;
    bit calm;
    out_stall <= 1'b0;
    taken = 0;
    calm  = 1'b0;
    @(posedge rst_n);
    forever begin
      if (taken % 64 == 0) calm = ($urandom_range(0, 2) == 0);
      hold = calm ? 0 : $urandom_range(0, 3);
      if (taken == HOLD_AT) hold = LONG_HOLD;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // stimulus and verdict
  initial begin
    mix_t mix;
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_item     <= '0;
    sender_calm = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty reads, transmit extremes, ignored offsets, no-op kind,
    // pushes by both paths, status with data, pops down to empty
    send_word(make_word(KIND_READ, OFS_STATUS, 8'h00));
    send_word(make_word(KIND_READ, OFS_DATA, 8'hFF));
    send_word(make_word(KIND_WRITE, OFS_DATA, 8'h00));
    send_word(make_word(KIND_WRITE, OFS_DATA, 8'hFF));
    send_word(make_word(KIND_WRITE, OFS_SPARE, 8'hAA));
    send_word(make_word(KIND_READ, OFS_SPARE, 8'h55));
    send_word(make_word(KIND_NONE, OFS_INJECT, 8'hFF));
    send_word(make_word(KIND_SERIAL, OFS_DATA, 8'hFF));
    send_word(make_word(KIND_WRITE, OFS_INJECT, 8'h00));
    send_word(make_word(KIND_SERIAL, OFS_BASE, 8'h5A));
    send_word(make_word(KIND_READ, OFS_STATUS, 8'h00));
    send_word(make_word(KIND_READ, OFS_DATA, 8'h00));
    send_word(make_word(KIND_READ, OFS_DATA, 8'h00));
    send_word(make_word(KIND_READ, OFS_DATA, 8'h00));
    send_word(make_word(KIND_READ, OFS_DATA, 8'h00));
    send_word(make_word(KIND_READ, OFS_STATUS, 8'h00));

    // random segments, each with its own mix and idling
    for (int s = 0; s < SEGMENTS; s++) begin
      mix         = mix_t'($urandom_range(0, 2));
      sender_calm = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < SEG_WORDS; i++) send_word(rand_word(mix));
    end
    in_valid <= 1'b0;

    // drain, then a few cycles for anything late
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/purf_pkg.sv
rtl/purf_ram.sv
rtl/purf_ctrl.sv
rtl/purf_dp.sv
rtl/polled_uart_rx_fifo_core.sv
test/uart_fifo_check.sv
test/polled_uart_rx_fifo_core_test.sv
